>>> design/assert_macros.svh
// Assertion macros shared by the tessellator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CBCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define CBCT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/cbct_pkg.sv
// Shared constants and types of the cubic B-spline curve tessellator.
package cbct_pkg;

    localparam int COORD_W       = 32;  // coordinate width, signed Q16.16
    localparam int CFG_W         = 6;   // segment_steps register width
    localparam int CFG_RESET     = 8;   // segment_steps after reset
    localparam int MAX_STEPS_DEF = 32;  // default largest segment_steps honored
    localparam int NTERMS        = 4;   // control points blended per curve point
    localparam int DIV_BITS      = 4;   // quotient bits resolved per divider cycle

    // Weights of the first curve point: (P0 + 4*P1 + P2) / 6
    localparam int FIRST_MID     = 4;
    localparam int FIRST_DIV     = 6;

    // Request into a shared unit
    typedef struct packed {
        logic start;
        logic first;
    } t_unit_ctl;

    // Status back from a shared unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

>>> design/cbct_if.sv
// Valid/ready channels for control points in and curve points out.
interface cbct_in_if import cbct_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      start_curve;
    logic signed [COORD_W-1:0] ctrl_x;
    logic signed [COORD_W-1:0] ctrl_y;
    logic signed [COORD_W-1:0] ctrl_z;

    modport source (output valid, start_curve, ctrl_x, ctrl_y, ctrl_z, input ready);
    modport sink   (input valid, start_curve, ctrl_x, ctrl_y, ctrl_z, output ready);
endinterface

interface cbct_out_if import cbct_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic signed [COORD_W-1:0] curve_z;
    logic                      run_end;

    modport source (output valid, curve_x, curve_y, curve_z, run_end, input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, run_end, output ready);
endinterface

>>> design/cbct_weight_gen.sv
// Three-stage pipeline that builds the four B-spline weights and the divisor for one step.
module cbct_weight_gen import cbct_pkg::*; #(
    parameter int  MAX_STEPS = MAX_STEPS_DEF,
    localparam int SW        = $clog2(MAX_STEPS + 1),
    localparam int WW        = 3 * SW + 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_unit_ctl     i_ctl,
    input  logic [SW-1:0] i_m,
    input  logic [SW-1:0] i_j,
    output t_unit_sts     o_sts,
    output logic [WW-1:0] o_w [NTERMS],
    output logic [WW-1:0] o_d
);

    logic            r_v1, r_v2, r_v3;
    logic            r1_first, r2_first;
    logic [SW-1:0]   r1_j, r1_a, r1_m;
    logic [2*SW-1:0] r1_j2, r1_a2, r1_m2;
    logic [3*SW-1:0] r2_j3, r2_a3, r2_m3, r2_mj2, r2_ma2;
    logic [SW-1:0]   a_in;
    logic [WW-1:0]   dj, da, wj, wa, m3x;

    // Mirrored step for the P0 and P2 weights counts down to zero at the end of the segment
    assign a_in = i_m - i_j;

    // Inner weights: 3*(i^3 - 2*m*i^2) + 4*m^3, wraps harmlessly in WW bits
    always_comb begin
        m3x = WW'(r2_m3);
        dj  = WW'(r2_j3) - (WW'(r2_mj2) << 1);
        da  = WW'(r2_a3) - (WW'(r2_ma2) << 1);
        wj  = dj + (dj << 1) + (m3x << 2);
        wa  = da + (da << 1) + (m3x << 2);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Squares, then cubes, then weights
    always_ff @(posedge i_clk) begin
        r1_first <= i_ctl.first;
        r1_j     <= i_j;
        r1_a     <= a_in;
        r1_m     <= i_m;
        r1_j2    <= i_j * i_j;
        r1_a2    <= a_in * a_in;
        r1_m2    <= i_m * i_m;

        r2_first <= r1_first;
        r2_j3    <= r1_j2 * r1_j;
        r2_a3    <= r1_a2 * r1_a;
        r2_m3    <= r1_m2 * r1_m;
        r2_mj2   <= r1_j2 * r1_m;
        r2_ma2   <= r1_a2 * r1_m;

        if (r_v2) begin
            if (r2_first) begin
                o_w[0] <= '0;
                o_w[1] <= WW'(1);
                o_w[2] <= WW'(FIRST_MID);
                o_w[3] <= WW'(1);
                o_d    <= WW'(FIRST_DIV);
            end else begin
                o_w[0] <= WW'(r2_a3);
                o_w[1] <= wj;
                o_w[2] <= wa;
                o_w[3] <= WW'(r2_j3);
                o_d    <= (m3x << 2) + (m3x << 1);
            end
        end
    end

    assign o_sts.busy = r_v1 | r_v2;
    assign o_sts.done = r_v3;

`include "assert_macros.svh"

    `CBCT_ASSERT(a_wg_latency, i_clk, i_rst_n, o_sts.done |-> $past(i_ctl.start, 3), "weights done without a request three cycles back")

endmodule

>>> design/cbct_blend_unit.sv
// Shared multiply-accumulate and radix-16 divider: one rounded blended coordinate per request.
module cbct_blend_unit import cbct_pkg::*; #(
    parameter int  MAX_STEPS = MAX_STEPS_DEF,
    localparam int SW        = $clog2(MAX_STEPS + 1),
    localparam int WW        = 3 * SW + 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [WW-1:0]             i_w [NTERMS],
    input  logic [WW-1:0]             i_d,
    input  logic signed [COORD_W-1:0] i_c [NTERMS],
    output t_unit_sts                 o_sts,
    output logic [COORD_W-1:0]        o_q
);

    localparam int QW   = ((COORD_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int NDIV = QW / DIV_BITS;
    localparam int DCW  = (NDIV > 1) ? $clog2(NDIV) : 1;
    localparam int AW   = WW + QW + 1;
    localparam int PW   = WW + 1 + COORD_W;
    localparam int KW   = $clog2(NTERMS + 1);

    typedef enum logic [1:0] {P_IDLE, P_MUL, P_LOAD, P_DIV} t_phase;

    t_phase                r_phase;
    logic [KW-1:0]         r_k;
    logic                  r_pv;
    logic                  r_done;
    logic [DCW-1:0]        r_cnt;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic [WW-1:0]         r_rem;
    logic [QW-1:0]         r_num;
    logic [WW-1:0]         n_rem;
    logic [QW-1:0]         n_num;

    // Resolve DIV_BITS quotient bits: shift in, compare, subtract
    always_comb begin
        logic [WW:0]   trial;
        logic [WW-1:0] rem;
        logic [QW-1:0] num;
        rem = r_rem;
        num = r_num;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem, num[QW-1]};
            num   = {num[QW-2:0], 1'b0};
            if (trial >= {1'b0, i_d}) begin
                trial  = trial - {1'b0, i_d};
                num[0] = 1'b1;
            end
            rem = trial[WW-1:0];
        end
        n_rem = rem;
        n_num = num;
    end

    // Sequence: seed accumulator with offset and half divisor, multiply, divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
            r_pv    <= 1'b0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            // Flag the result together with o_q once the last divide cycle ends
            r_done <= (r_phase == P_DIV) && (r_cnt == DCW'(NDIV - 1));
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        // Offset of d*2^(W-1) keeps the sum nonnegative; d/2 rounds
                        r_acc   <= $signed((AW'(i_d) << (COORD_W - 1)) + AW'(i_d >> 1));
                        r_k     <= '0;
                        r_pv    <= 1'b0;
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    if (r_k != KW'(NTERMS)) begin
                        r_prod <= $signed({1'b0, i_w[r_k[KW-2:0]]}) * i_c[r_k[KW-2:0]];
                    end
                    r_pv <= (r_k != KW'(NTERMS));
                    if (r_pv) begin
                        r_acc <= r_acc + AW'(r_prod);
                    end
                    if (r_k == KW'(NTERMS)) begin
                        r_phase <= P_LOAD;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                P_LOAD: begin
                    r_rem   <= r_acc[QW +: WW];
                    r_num   <= r_acc[QW-1:0];
                    r_cnt   <= '0;
                    r_phase <= P_DIV;
                end
                P_DIV: begin
                    r_rem <= n_rem;
                    r_num <= n_num;
                    if (r_cnt == DCW'(NDIV - 1)) begin
                        // Drop the offset: subtract 2^(W-1) by flipping the sign bit
                        o_q     <= {~n_num[COORD_W-1], n_num[COORD_W-2:0]};
                        r_phase <= P_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_phase != P_IDLE);
    assign o_sts.done = r_done;

`include "assert_macros.svh"

    `CBCT_ASSERT(a_bl_no_restart, i_clk, i_rst_n, i_start |-> r_phase == P_IDLE,
                 "blend request while busy")

endmodule

>>> design/cubic_bspline_curve_tessellator_top.sv
// Top level of the cubic B-spline curve tessellator: window, sequencer and output register.
// The first two points of a curve are only stored and give no curve point.
// Each curve point passes the weight pipeline, then the shared unit once per axis (start,
// multiply-accumulate, load, radix-16 divide, hand-off), then the output register. The third
// point gives one curve point, a later one segment_steps; a stalled receiver holds them.
// Synchronous active-low reset clears the window, the point count and sets segment_steps to 8.
module cubic_bspline_curve_tessellator_top import cbct_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    cbct_in_if.sink          i_pt,
    cbct_out_if.source       o_pt
);

    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int WW = 3 * SW + 3;

    typedef enum logic [1:0] {S_IDLE, S_WGT, S_BLEND, S_OUT} t_state;
    typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} t_axis;

    t_state                    r_state;
    t_axis                     r_axis;
    logic [CFG_W-1:0]          r_cfg;
    logic [1:0]                r_seen;
    logic                      r_first;
    logic [SW-1:0]             r_m;
    logic [SW-1:0]             r_j;
    logic                      r_wg_start;
    logic                      r_bl_start;
    logic signed [COORD_W-1:0] r_win_x [3];
    logic signed [COORD_W-1:0] r_win_y [3];
    logic signed [COORD_W-1:0] r_win_z [3];
    logic signed [COORD_W-1:0] r_pt_x, r_pt_y, r_pt_z;
    logic [COORD_W-1:0]        r_res_x, r_res_y, r_res_z;
    logic                      r_o_valid;
    logic [COORD_W-1:0]        r_o_x, r_o_y, r_o_z;
    logic                      r_o_end;

    logic                      in_acc;
    logic                      out_free;
    logic [1:0]                seen;
    logic [SW-1:0]             m_eff;
    logic                      last;
    t_unit_ctl                 wg_ctl;
    t_unit_sts                 wg_sts;
    t_unit_sts                 bl_sts;
    logic [WW-1:0]             wg_w [NTERMS];
    logic [WW-1:0]             wg_d;
    logic signed [COORD_W-1:0] bl_c [NTERMS];
    logic [COORD_W-1:0]        bl_q;

    assign in_acc   = i_pt.valid && i_pt.ready;
    assign out_free = !r_o_valid || o_pt.ready;
    assign seen     = i_pt.start_curve ? 2'd0 : r_seen;
    assign last     = r_first || (r_j == r_m);

    // Clamp segment_steps into 1..MAX_STEPS
    always_comb begin
        if (r_cfg == '0) begin
            m_eff = SW'(1);
        end else if (int'(r_cfg) > MAX_STEPS) begin
            m_eff = SW'(MAX_STEPS);
        end else begin
            m_eff = SW'(r_cfg);
        end
    end

    // Feed the blend unit the four points of the current axis
    always_comb begin
        unique case (r_axis)
            AX_X: begin
                bl_c[0] = r_win_x[0];
                bl_c[1] = r_win_x[1];
                bl_c[2] = r_win_x[2];
                bl_c[3] = r_pt_x;
            end
            AX_Y: begin
                bl_c[0] = r_win_y[0];
                bl_c[1] = r_win_y[1];
                bl_c[2] = r_win_y[2];
                bl_c[3] = r_pt_y;
            end
            AX_Z: begin
                bl_c[0] = r_win_z[0];
                bl_c[1] = r_win_z[1];
                bl_c[2] = r_win_z[2];
                bl_c[3] = r_pt_z;
            end
            default: begin
                bl_c[0] = '0;
                bl_c[1] = '0;
                bl_c[2] = '0;
                bl_c[3] = '0;
            end
        endcase
    end

    assign wg_ctl.start = r_wg_start;
    assign wg_ctl.first = r_first;

    cbct_weight_gen #(.MAX_STEPS(MAX_STEPS)) u_weight_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (wg_ctl),
        .i_m     (r_m),
        .i_j     (r_j),
        .o_sts   (wg_sts),
        .o_w     (wg_w),
        .o_d     (wg_d)
    );

    cbct_blend_unit #(.MAX_STEPS(MAX_STEPS)) u_blend_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_bl_start),
        .i_w     (wg_w),
        .i_d     (wg_d),
        .i_c     (bl_c),
        .o_sts   (bl_sts),
        .o_q     (bl_q)
    );

    // Sequencer, window and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis     <= AX_X;
            r_cfg      <= CFG_W'(CFG_RESET);
            r_seen     <= 2'd0;
            r_first    <= 1'b0;
            r_m        <= SW'(1);
            r_j        <= SW'(1);
            r_wg_start <= 1'b0;
            r_bl_start <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_win_x[i] <= '0;
                r_win_y[i] <= '0;
                r_win_z[i] <= '0;
            end
        end else begin
            // Kick the weight pipeline for a new point or the next step
            r_wg_start <= ((r_state == S_IDLE) && in_acc && (seen >= 2'd2)) ||
                          ((r_state == S_OUT) && out_free && !last);
            // Kick the blend unit once weights are ready and after each of x and y
            r_bl_start <= ((r_state == S_WGT) && wg_sts.done) ||
                          ((r_state == S_BLEND) && bl_sts.done &&
                           ((r_axis == AX_X) || (r_axis == AX_Y)));
            // Load a new result, else drop the held one once taken
            if ((r_state == S_OUT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_pt.valid && o_pt.ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pt_x <= i_pt.ctrl_x;
                        r_pt_y <= i_pt.ctrl_y;
                        r_pt_z <= i_pt.ctrl_z;
                        if (seen < 2'd2) begin
                            // Opening points of a curve: store only
                            r_win_x[0] <= r_win_x[1];
                            r_win_x[1] <= r_win_x[2];
                            r_win_x[2] <= i_pt.ctrl_x;
                            r_win_y[0] <= r_win_y[1];
                            r_win_y[1] <= r_win_y[2];
                            r_win_y[2] <= i_pt.ctrl_y;
                            r_win_z[0] <= r_win_z[1];
                            r_win_z[1] <= r_win_z[2];
                            r_win_z[2] <= i_pt.ctrl_z;
                            r_seen     <= seen + 2'd1;
                        end else begin
                            r_first    <= (seen == 2'd2);
                            r_seen     <= 2'd3;
                            r_m        <= m_eff;
                            r_j        <= SW'(1);
                            r_state    <= S_WGT;
                        end
                    end
                end
                S_WGT: begin
                    if (wg_sts.done) begin
                        r_axis     <= AX_X;
                        r_state    <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    if (bl_sts.done) begin
                        unique case (r_axis)
                            AX_X: begin
                                r_res_x    <= bl_q;
                                r_axis     <= AX_Y;
                            end
                            AX_Y: begin
                                r_res_y    <= bl_q;
                                r_axis     <= AX_Z;
                            end
                            AX_Z: begin
                                r_res_z <= bl_q;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_x     <= r_res_x;
                        r_o_y     <= r_res_y;
                        r_o_z     <= r_res_z;
                        r_o_end   <= last;
                        if (last) begin
                            // Segment done: shift the new point into the window
                            r_win_x[0] <= r_win_x[1];
                            r_win_x[1] <= r_win_x[2];
                            r_win_x[2] <= r_pt_x;
                            r_win_y[0] <= r_win_y[1];
                            r_win_y[1] <= r_win_y[2];
                            r_win_y[2] <= r_pt_y;
                            r_win_z[0] <= r_win_z[1];
                            r_win_z[1] <= r_win_z[2];
                            r_win_z[2] <= r_pt_z;
                            r_state    <= S_IDLE;
                        end else begin
                            r_j        <= r_j + 1'b1;
                            r_state    <= S_WGT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_pt.ready     = (r_state == S_IDLE);
    assign o_pt.valid     = r_o_valid;
    assign o_pt.curve_x   = r_o_x;
    assign o_pt.curve_y   = r_o_y;
    assign o_pt.curve_z   = r_o_z;
    assign o_pt.run_end   = r_o_end;

`include "assert_macros.svh"

    `CBCT_ASSERT(a_ready_units_idle, i_clk, i_rst_n,
                 i_pt.ready |-> !wg_sts.busy && !bl_sts.busy,
                 "input ready while a shared unit is busy")
    `CBCT_ASSERT(a_blend_done_state, i_clk, i_rst_n, bl_sts.done |-> r_state == S_BLEND,
                 "blend result outside the blend state")
    `CBCT_NEVER(a_busy_without_window, i_clk, i_rst_n,
                r_state != S_IDLE && r_seen != 2'd3,
                "curve point work before three points seen")

endmodule
